[rtl/core/pfc_pkg.sv]
`timescale 1ns / 1ps
package pfc_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_OUTSIDE  = 3'd0;
  localparam logic [2:0] PH_AT_FIRST = 3'd1;
  localparam logic [2:0] PH_FLAGS    = 3'd2;
  localparam logic [2:0] PH_PRE_DOT  = 3'd3;
  localparam logic [2:0] PH_AT_DOT   = 3'd4;
  localparam logic [2:0] PH_POST_DOT = 3'd5;
  localparam logic [2:0] PH_AT_LAST  = 3'd6;

  // Segment classes
  localparam logic [1:0] CLS_LITERAL = 2'd0;
  localparam logic [1:0] CLS_INT     = 2'd1;
  localparam logic [1:0] CLS_FLOAT   = 2'd2;
  localparam logic [1:0] CLS_PERCENT = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_UNFINISHED = 2'd2;

  // Characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;

  typedef struct packed {
    logic       is_flag;
    logic       is_nz_digit;
    logic       is_digit;
    logic       is_dot;
    logic       is_percent;
    logic [1:0] letter_class;
  } char_info_t;

  typedef struct packed {
    logic       split_before;
    logic [1:0] split_class;
    logic [1:0] end_class;
    logic [1:0] status;
  } step_result_t;

endpackage

[rtl/core/pfc_char_decode.sv]
`timescale 1ns / 1ps
module pfc_char_decode (
  input  logic [7:0]              ch,
  output pfc_pkg::char_info_t     info
);

  always_comb begin
    info.is_flag = (ch == pfc_pkg::CH_HASH) || (ch == pfc_pkg::CH_ZERO) ||
                   (ch == pfc_pkg::CH_SPACE) || (ch == pfc_pkg::CH_QUOTE) ||
                   (ch == pfc_pkg::CH_PLUS) || (ch == pfc_pkg::CH_MINUS);
    info.is_nz_digit = (ch >= pfc_pkg::CH_ONE) && (ch <= pfc_pkg::CH_NINE);
    info.is_digit    = (ch >= pfc_pkg::CH_ZERO) && (ch <= pfc_pkg::CH_NINE);
    info.is_dot      = (ch == pfc_pkg::CH_DOT);
    info.is_percent  = (ch == pfc_pkg::CH_PERCENT);
    // conversion letters
    case (ch)
      8'h64, 8'h69, 8'h6f, 8'h75, 8'h78, 8'h58, 8'h63:
        info.letter_class = pfc_pkg::CLS_INT;
      8'h65, 8'h66, 8'h67, 8'h45, 8'h46, 8'h47:
        info.letter_class = pfc_pkg::CLS_FLOAT;
      default:
        info.letter_class = pfc_pkg::CLS_LITERAL;
    endcase
  end

endmodule

[rtl/core/pfc_parse.sv]
`timescale 1ns / 1ps
module pfc_parse (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step_en,
  input  pfc_pkg::char_info_t     info,
  input  logic                    last,
  output pfc_pkg::step_result_t   result
);

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [1:0] seg_class;
  logic [1:0] seg_class_next;
  logic       nonempty;
  logic       nonempty_next;
  logic       err;
  logic       err_next;

  logic [2:0] ph;
  logic [1:0] cls;
  logic       err_new;

  always_comb begin
    ph = phase;
    cls = seg_class;
    err_new = err;
    result.split_before = 1'b0;
    result.split_class  = pfc_pkg::CLS_LITERAL;
    result.end_class    = pfc_pkg::CLS_LITERAL;
    result.status       = pfc_pkg::ST_OK;

    if (!err) begin
      case (phase)
        pfc_pkg::PH_AT_FIRST: begin
          if (info.is_flag) ph = pfc_pkg::PH_FLAGS;
          else if (info.is_nz_digit) ph = pfc_pkg::PH_PRE_DOT;
          else if (info.is_dot) ph = pfc_pkg::PH_AT_DOT;
          else if (info.letter_class != pfc_pkg::CLS_LITERAL) begin
            cls = info.letter_class;
            ph = pfc_pkg::PH_AT_LAST;
          end else if (info.is_percent) begin
            cls = pfc_pkg::CLS_PERCENT;
            ph = pfc_pkg::PH_AT_LAST;
          end else err_new = 1'b1;
        end
        pfc_pkg::PH_FLAGS: begin
          if (info.is_flag) ph = pfc_pkg::PH_FLAGS;
          else if (info.is_nz_digit) ph = pfc_pkg::PH_PRE_DOT;
          else if (info.is_dot) ph = pfc_pkg::PH_AT_DOT;
          else if (info.letter_class != pfc_pkg::CLS_LITERAL) begin
            cls = info.letter_class;
            ph = pfc_pkg::PH_AT_LAST;
          end else err_new = 1'b1;
        end
        pfc_pkg::PH_PRE_DOT: begin
          if (info.is_digit) ph = pfc_pkg::PH_PRE_DOT;
          else if (info.is_dot) ph = pfc_pkg::PH_AT_DOT;
          else if (info.letter_class != pfc_pkg::CLS_LITERAL) begin
            cls = info.letter_class;
            ph = pfc_pkg::PH_AT_LAST;
          end else err_new = 1'b1;
        end
        pfc_pkg::PH_AT_DOT, pfc_pkg::PH_POST_DOT: begin
          if (info.is_digit) ph = pfc_pkg::PH_POST_DOT;
          else if (info.letter_class == pfc_pkg::CLS_FLOAT) begin
            cls = info.letter_class;
            ph = pfc_pkg::PH_AT_LAST;
          end else err_new = 1'b1;
        end
        default: begin
          // outside a specifier or just after a conversion
          if (info.is_percent) begin
            if (nonempty && seg_class != pfc_pkg::CLS_PERCENT) begin
              result.split_before = 1'b1;
              result.split_class  = seg_class;
              cls = pfc_pkg::CLS_LITERAL;
            end
            ph = pfc_pkg::PH_AT_FIRST;
          end else begin
            ph = pfc_pkg::PH_OUTSIDE;
          end
        end
      endcase
    end

    if (err_new) begin
      result.split_before = 1'b0;
      result.split_class  = pfc_pkg::CLS_LITERAL;
      result.status       = pfc_pkg::ST_INVALID;
    end else if (last && ph != pfc_pkg::PH_OUTSIDE && ph != pfc_pkg::PH_AT_LAST) begin
      result.status = pfc_pkg::ST_UNFINISHED;
    end else if (last) begin
      result.end_class = cls;
    end

    if (last) begin
      phase_next     = pfc_pkg::PH_OUTSIDE;
      seg_class_next = pfc_pkg::CLS_LITERAL;
      nonempty_next  = 1'b0;
      err_next       = 1'b0;
    end else begin
      phase_next     = ph;
      seg_class_next = cls;
      nonempty_next  = nonempty | ~err;
      err_next       = err_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= pfc_pkg::PH_OUTSIDE;
      seg_class <= pfc_pkg::CLS_LITERAL;
      nonempty  <= 1'b0;
      err       <= 1'b0;
    end else if (step_en) begin
      phase     <= phase_next;
      seg_class <= seg_class_next;
      nonempty  <= nonempty_next;
      err       <= err_next;
    end
  end

`ifndef SYNTHESIS
  // a split never happens while an earlier error is pending
  a_no_split_after_err: assert property (@(posedge clk) disable iff (rst)
    step_en && err |-> !result.split_before)
    else $error("split reported after error");

  // the last byte returns the parser to its reset state
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    step_en && last |=> phase == pfc_pkg::PH_OUTSIDE && !nonempty && !err &&
                        seg_class == pfc_pkg::CLS_LITERAL)
    else $error("state not cleared after last byte");

  // the error flag only rises on an accepted byte
  a_err_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(err) |-> $past(step_en) && !$past(last))
    else $error("error flag rose without a byte");
`endif

endmodule

[rtl/core/printf_format_spec_checker.sv]
`timescale 1ns / 1ps
// A request passes through the input register and then the result register before its result is offered.
// Throughput: one byte per cycle, sustained, while the result side takes one per cycle.
// The result register frees its slot in the same cycle that the result is taken.
// Reset (rst, synchronous, active high) clears both valid flags and the parser
// state: outside a specifier, literal segment, empty, no error.
module printf_format_spec_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       split_before,
  output logic [1:0] split_class,
  output logic [1:0] end_class,
  output logic [1:0] status,
  output logic       done_res
);

  // Input register: holds one request until the parser step can take it.
  logic       in_full;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Result register
  logic       res_full;

  logic                  advance;
  logic                  out_free;
  pfc_pkg::char_info_t   info;
  pfc_pkg::step_result_t step_res;

  // The result slot is free when empty or being taken this cycle.
  assign out_free = !res_full || !out_stall;
  // Advance the parser whenever a byte waits and the result slot is free.
  assign advance  = in_full && out_free;
  // Stall the input while the held byte cannot move on.
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_last_r <= is_last;
    end
  end

  pfc_char_decode u_decode (
    .ch   (in_byte_r),
    .info (info)
  );

  pfc_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .info    (info),
    .last    (in_last_r),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (out_free) begin
      res_full <= advance;
    end
  end

  // Load the result payload on each parser step.
  always_ff @(posedge clk) begin
    if (advance) begin
      split_before <= step_res.split_before;
      split_class  <= step_res.split_class;
      end_class    <= step_res.end_class;
      status       <= step_res.status;
      done_res     <= in_last_r;
    end
  end

  assign out_valid = res_full;

`ifndef SYNTHESIS
  // unfinished status only on the final byte of a string
  a_unfinished_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == pfc_pkg::ST_UNFINISHED |-> done_res)
    else $error("unfinished status before last byte");

  // no split class without a split
  a_split_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && !split_before |-> split_class == pfc_pkg::CLS_LITERAL)
    else $error("split class without split");

  // end class only on a clean final byte
  a_end_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!done_res || status != pfc_pkg::ST_OK) |->
      end_class == pfc_pkg::CLS_LITERAL)
    else $error("end class outside a clean last byte");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == pfc_pkg::ST_OK || status == pfc_pkg::ST_INVALID ||
                  status == pfc_pkg::ST_UNFINISHED)
    else $error("undefined status code");
`endif

endmodule
